### rtl/core/chained_range_offset_map_macros.svh
// Assertion macros for the chained range offset map.
// Included by the queue and back-end modules; no other dependencies.
`ifndef CHAINED_RANGE_OFFSET_MAP_MACROS_SVH
`define CHAINED_RANGE_OFFSET_MAP_MACROS_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define CROM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crom assertion failed");
// Check that cons holds in the cycle after ante
`define CROM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crom assertion failed");
`else
`define CROM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CROM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/crom_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chained range offset map.
// No dependencies.

package crom_pkg;

  // Default sizing of the translation chain
  localparam int STAGE_COUNT_DEF     = 7;
  localparam int RULES_PER_STAGE_DEF = 32;
  localparam int VALUE_BITS_DEF      = 40;
  localparam int QUEUE_DEPTH         = 2;

  // Fixed field widths of the channels
  localparam int REQ_W       = 2;
  localparam int STAGE_IDX_W = 3;
  localparam int SLOT_IDX_W  = 5;
  localparam int FIELD_W     = 40;
  localparam int LAST_W      = 41;
  localparam int OFFSET_W    = 41;

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Operations handed from front end to back end
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  // One range rule as stored
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LAST_W-1:0]   last;
    logic [FIELD_W-1:0]  first;
  } rule_t;

  // One queued operation
  typedef struct packed {
    op_t                    op;
    logic [STAGE_IDX_W-1:0] stage;
    logic [SLOT_IDX_W-1:0]  slot;
    logic                   rule_on;
    rule_t                  rule;
    logic [FIELD_W-1:0]     query;
  } q_entry_t;

endpackage

### rtl/core/crom_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result beats.
// Depends on crom_pkg.

interface crom_in_if
  import crom_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [STAGE_IDX_W-1:0]     stage_index;
  logic [SLOT_IDX_W-1:0]      slot_index;
  logic [FIELD_W-1:0]         range_start;
  logic [FIELD_W-1:0]         range_length;
  logic signed [OFFSET_W-1:0] offset_value;
  logic [FIELD_W-1:0]         query_value;

  modport source (
    output valid, req_type, stage_index, slot_index, range_start, range_length,
           offset_value, query_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, stage_index, slot_index, range_start, range_length,
           offset_value, query_value,
    output ready
  );
endinterface

interface crom_out_if
  import crom_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] mapped_value;
  logic [FIELD_W-1:0] minimum_value;

  modport source (output valid, mapped_value, minimum_value, input ready);
  modport sink (input valid, mapped_value, minimum_value, output ready);
endinterface

### rtl/core/crom_front.sv
`timescale 1ns / 1ps
// Front end: accepts request beats, drops unusable ones, builds queue entries.
// Depends on crom_pkg and crom_in_if.

module crom_front
  import crom_pkg::*;
#(
  parameter int STAGE_COUNT     = STAGE_COUNT_DEF,
  parameter int RULES_PER_STAGE = RULES_PER_STAGE_DEF
) (
  crom_in_if.sink    in_ch,
  output q_entry_t   push_entry,
  output logic       push_valid,
  input  logic       push_ready
);

  logic              keep;
  logic              load_ok;
  logic [LAST_W-1:0] last_sum;

  // Accept whenever the queue has room; dropped beats vanish here
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && keep;

  // Loads aimed outside the table are ignored
  assign load_ok = (32'(in_ch.stage_index) < STAGE_COUNT) &&
                   (32'(in_ch.slot_index) < RULES_PER_STAGE);

  // Inclusive end of the loaded range
  assign last_sum = {1'b0, in_ch.range_start} + {1'b0, in_ch.range_length} - LAST_W'(1);

  // Classify the beat
  always_comb begin
    keep                  = 1'b0;
    push_entry.op         = OP_QUERY;
    push_entry.stage      = in_ch.stage_index;
    push_entry.slot       = in_ch.slot_index;
    push_entry.rule_on    = (in_ch.range_length != '0);
    push_entry.rule.first = in_ch.range_start;
    push_entry.rule.last  = push_entry.rule_on ? last_sum : '0;
    push_entry.rule.offset = in_ch.offset_value;
    push_entry.query      = in_ch.query_value;
    case (in_ch.req_type)
      REQ_LOAD: begin
        keep          = load_ok;
        push_entry.op = OP_LOAD;
      end
      REQ_QUERY: begin
        keep          = 1'b1;
        push_entry.op = OP_QUERY;
      end
      REQ_CLEAR: begin
        keep          = 1'b1;
        push_entry.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/crom_queue.sv
`timescale 1ns / 1ps
// Short FIFO of operations between front end and back end.
// Depends on crom_pkg and the assertion macro header.
`include "chained_range_offset_map_macros.svh"

module crom_queue
  import crom_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  q_entry_t push_entry,
  input  logic     push_valid,
  output logic     push_ready,
  output q_entry_t pop_entry,
  output logic     pop_valid,
  input  logic     pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_entry  = slots_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `CROM_ASSERT_NOW(a_q_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `CROM_ASSERT_NEXT(a_q_grow, clk, rst_n, push_fire && !pop_fire, count_r == $past(count_r) + CNT_W'(1))

endmodule

### rtl/core/crom_back.sv
`timescale 1ns / 1ps
// Back end: rule storage, stage-by-stage translation and result register.
// Depends on crom_pkg, crom_out_if and the assertion macro header.
`include "chained_range_offset_map_macros.svh"

module crom_back
  import crom_pkg::*;
#(
  parameter int STAGE_COUNT     = STAGE_COUNT_DEF,
  parameter int RULES_PER_STAGE = RULES_PER_STAGE_DEF,
  parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    pop_entry,
  input  logic        pop_valid,
  output logic        pop_ready,
  crom_out_if.source  out_ch
);

  localparam int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int SLOT_W  = (RULES_PER_STAGE > 1) ? $clog2(RULES_PER_STAGE) : 1;
  localparam int CMP_W   = (VALUE_BITS > LAST_W) ? VALUE_BITS : LAST_W;
  localparam int SUM_W   = CMP_W + 2;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
  localparam logic [STAGE_W-1:0]    LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                     state_r;
  logic [STAGE_W-1:0]         stage_r;
  logic [VALUE_BITS-1:0]      v_r;
  logic [VALUE_BITS-1:0]      min_r;
  logic                       seen_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [FIELD_W-1:0]         out_mapped_r;
  logic [FIELD_W-1:0]         out_min_r;

  rule_t [RULES_PER_STAGE-1:0] rule_mem [STAGE_COUNT];
  logic [RULES_PER_STAGE-1:0]  valid_r  [STAGE_COUNT];
  rule_t [RULES_PER_STAGE-1:0] row_r;
  logic [RULES_PER_STAGE-1:0]  row_valid_r;

  logic                       pop_fire;
  logic                       out_free;
  logic [STAGE_W-1:0]         rd_stage;
  logic [STAGE_W-1:0]         wr_stage;
  logic [SLOT_W-1:0]          wr_slot;
  logic [CMP_W-1:0]           v_ext;
  logic [CMP_W-1:0]           q_ext;
  logic [VALUE_BITS-1:0]      q_sat;
  logic                       hit;
  logic [OFFSET_W-1:0]        sel_off;
  logic signed [SUM_W-1:0]    v_s;
  logic signed [SUM_W-1:0]    off_s;
  logic signed [SUM_W-1:0]    sum_s;
  logic signed [SUM_W-1:0]    vmax_s;
  logic [VALUE_BITS-1:0]      step_v;
  logic [VALUE_BITS-1:0]      min_nxt;

  assign pop_ready = (state_r == ST_IDLE);
  assign pop_fire  = pop_valid && pop_ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mapped_value  = out_mapped_r;
  assign out_ch.minimum_value = out_min_r;

  // Raise the result beat when done, hold it until taken
  assign out_valid_nxt = (state_r == ST_DONE && out_free) || (out_valid_r && !out_ch.ready);

  // Prefetch the row of the next stage; row 0 while idle
  assign rd_stage = (state_r == ST_RUN && stage_r != LAST_STAGE) ?
                    stage_r + STAGE_W'(1) : '0;
  assign wr_stage = STAGE_W'(pop_entry.stage);
  assign wr_slot  = SLOT_W'(pop_entry.slot);

  // Rule storage: one row per stage, written one slot at a time
  always_ff @(posedge clk) begin
    if (pop_fire && pop_entry.op == OP_LOAD) begin
      rule_mem[wr_stage][wr_slot] <= pop_entry.rule;
    end
    row_r <= rule_mem[rd_stage];
  end

  // Rule valid bits, cleared at once by reset or a clear beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGE_COUNT; s++) begin
        valid_r[s] <= '0;
      end
      row_valid_r <= '0;
    end else begin
      if (pop_fire && pop_entry.op == OP_CLEAR) begin
        for (int s = 0; s < STAGE_COUNT; s++) begin
          valid_r[s] <= '0;
        end
      end else if (pop_fire && pop_entry.op == OP_LOAD) begin
        valid_r[wr_stage][wr_slot] <= pop_entry.rule_on;
      end
      row_valid_r <= valid_r[rd_stage];
    end
  end

  // Clamp the incoming query to the value range
  assign q_ext = CMP_W'(pop_entry.query);
  assign q_sat = (q_ext > CMP_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_BITS'(q_ext);

  // Compare all rules of the current stage; lowest matching slot wins
  assign v_ext = CMP_W'(v_r);
  always_comb begin
    hit     = 1'b0;
    sel_off = '0;
    for (int r = RULES_PER_STAGE - 1; r >= 0; r--) begin
      if (row_valid_r[r] && (CMP_W'(row_r[r].first) <= v_ext) &&
          (v_ext <= CMP_W'(row_r[r].last))) begin
        hit     = 1'b1;
        sel_off = row_r[r].offset;
      end
    end
  end

  // Add the offset and saturate to the value range
  assign v_s    = $signed({{(SUM_W - VALUE_BITS){1'b0}}, v_r});
  assign off_s  = $signed({{(SUM_W - OFFSET_W){sel_off[OFFSET_W-1]}}, sel_off});
  assign vmax_s = $signed({{(SUM_W - VALUE_BITS){1'b0}}, VALUE_MAX});
  assign sum_s  = v_s + off_s;

  always_comb begin
    if (!hit) begin
      step_v = v_r;
    end else if (sum_s < 0) begin
      step_v = '0;
    end else if (sum_s > vmax_s) begin
      step_v = VALUE_MAX;
    end else begin
      step_v = VALUE_BITS'(sum_s);
    end
  end

  assign min_nxt = (!seen_r || v_r < min_r) ? v_r : min_r;

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stage_r      <= '0;
      v_r          <= '0;
      min_r        <= VALUE_MAX;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_mapped_r <= '0;
      out_min_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (pop_fire) begin
            case (pop_entry.op)
              OP_QUERY: begin
                v_r     <= q_sat;
                stage_r <= '0;
                state_r <= ST_RUN;
              end
              OP_CLEAR: begin
                min_r  <= VALUE_MAX;
                seen_r <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          v_r <= step_v;
          if (stage_r == LAST_STAGE) begin
            state_r <= ST_DONE;
          end else begin
            stage_r <= stage_r + STAGE_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_mapped_r <= FIELD_W'(v_r);
            out_min_r    <= FIELD_W'(min_nxt);
            min_r        <= min_nxt;
            seen_r       <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `CROM_ASSERT_NOW(a_stage_range, clk, rst_n, state_r == ST_RUN, stage_r <= LAST_STAGE)
  `CROM_ASSERT_NOW(a_min_le_mapped, clk, rst_n, out_valid_r, out_min_r <= out_mapped_r)
  `CROM_ASSERT_NEXT(a_done_emits, clk, rst_n, state_r == ST_DONE && out_free, out_valid_r && state_r == ST_IDLE)

endmodule

### rtl/core/chained_range_offset_map.sv
// Top level of the chained range offset map: front end, operation queue, back end.
// Depends on crom_pkg, crom_channels, crom_front, crom_queue and crom_back.
//
// A query value passes through STAGE_COUNT translation stages; in each stage the
// lowest valid slot whose closed range holds the value adds its signed offset,
// saturated to [0, 2^VALUE_BITS - 1], and the result beat carries the final value
// and the running minimum since the last clear. A query is taken from the queue
// while the first rule row is read; then, stage by stage, all RULES_PER_STAGE
// rules of that stage are compared and the offset is added; last, the result
// register is written once any previous result beat has been taken. Load and
// clear beats act when taken from the queue, and dropped beats never enter it.
// Rule rows sit in a memory of STAGE_COUNT rows with one read port, so stages
// run strictly in order. A two-entry queue sits between the front end and the
// back end, so new beats are taken while it has room, also while a query is in
// flight or a result waits. Rule valid bits are flip-flops cleared by reset, so
// no clearing pass follows reset.
`timescale 1ns / 1ps

module chained_range_offset_map
  import crom_pkg::*;
#(
  parameter int STAGE_COUNT     = STAGE_COUNT_DEF,
  parameter int RULES_PER_STAGE = RULES_PER_STAGE_DEF,
  parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  crom_in_if.sink    in_ch,
  crom_out_if.source out_ch
);

  q_entry_t push_entry;
  logic     push_valid;
  logic     push_ready;
  q_entry_t pop_entry;
  logic     pop_valid;
  logic     pop_ready;

  // Classify incoming beats
  crom_front #(
    .STAGE_COUNT     (STAGE_COUNT),
    .RULES_PER_STAGE (RULES_PER_STAGE)
  ) u_front (
    .in_ch      (in_ch),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouple front and back
  crom_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Execute loads, clears and queries
  crom_back #(
    .STAGE_COUNT     (STAGE_COUNT),
    .RULES_PER_STAGE (RULES_PER_STAGE),
    .VALUE_BITS      (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
